[sv/sbi_pkg.sv]
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared constants and types for the segment / box intersection test.
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // outcode bit positions
    localparam int OC_LEFT  = 0;
    localparam int OC_RIGHT = 1;
    localparam int OC_BELOW = 2;
    localparam int OC_ABOVE = 3;

    // pure straddle codes
    localparam logic [3:0] OC_STRADDLE_X = 4'd3;
    localparam logic [3:0] OC_STRADDLE_Y = 4'd12;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

[sv/sbi_if.sv]
// ----------------------------------------------------------------------------
// sbi_req_if / sbi_rsp_if
// Valid/ready channels for requests (box + segment) and results (hit flag).
// ----------------------------------------------------------------------------
interface sbi_req_if #(
    parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (
        output valid, box_min_x, box_min_y, box_max_x, box_max_y,
               start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
               start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface sbi_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

[sv/segment_box_intersect_test.sv]
// Pipeline: 3 stages; an accepted request passes the stage 1, 2 and 3 registers before its result is valid.
// Throughput: one request per cycle while the sink takes results; stages advance independently, bubbles collapse.
// Ready drops only when all three stages hold results and the sink stalls.
// Reset (synchronous, active low) clears the stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// segment_box_intersect_test
// Segment versus axis-aligned box hit test: outcode prefilter, exact edge test.
// ----------------------------------------------------------------------------
module segment_box_intersect_test #(
    parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbi_req_if.sink   i_req,
    sbi_rsp_if.source o_rsp
);
    import sbi_pkg::*;

    logic      r_v1, r_v2, r_v3;
    logic      adv1, adv2, adv3;
    t_stage_en en;

    assign adv3 = !r_v3 || o_rsp.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign en.s1 = adv1;
    assign en.s2 = adv2;
    assign en.s3 = adv3;

    assign i_req.ready = adv1;
    assign o_rsp.valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_req.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    sbi_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_box_min_x (i_req.box_min_x),
        .i_box_min_y (i_req.box_min_y),
        .i_box_max_x (i_req.box_max_x),
        .i_box_max_y (i_req.box_max_y),
        .i_start_x   (i_req.start_x),
        .i_start_y   (i_req.start_y),
        .i_end_x     (i_req.end_x),
        .i_end_y     (i_req.end_y),
        .o_hit       (o_rsp.hit)
    );

endmodule

[sv/sbi_datapath.sv]
// ----------------------------------------------------------------------------
// sbi_datapath
// Three-stage datapath: deltas and outcodes, edge cross products, sign test.
// ----------------------------------------------------------------------------
module sbi_datapath #(
    parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  sbi_pkg::t_stage_en            i_en,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_hit
);
    import sbi_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int KW = PW + 1;

    // stage 1
    logic [3:0]           ca, cb, cor;
    logic                 n_fix, n_fix_hit;
    logic [3:0]           n_edge_ok;
    logic signed [DW-1:0] n_dx, n_dy, n_ll, n_rr, n_tt, n_bb;

    logic signed [DW-1:0] r1_dx, r1_dy, r1_ll, r1_rr, r1_tt, r1_bb;
    logic [3:0]           r1_edge_ok;
    logic                 r1_fix, r1_fix_hit;

    // stage 2
    logic signed [PW-1:0] r2_dxt, r2_dxb, r2_dyl, r2_dyr;
    logic [3:0]           r2_edge_ok;
    logic                 r2_fix, r2_fix_hit;

    // stage 3
    logic signed [KW-1:0] k_lt, k_lb, k_rt, k_rb;
    logic                 n_hit;
    logic                 r3_hit;

    function automatic logic straddle(logic a_lt, logic a_eq, logic b_lt, logic b_eq);
        straddle = a_eq | b_eq | (a_lt != b_lt);
    endfunction

    function automatic logic meet(logic signed [KW-1:0] a, logic signed [KW-1:0] b);
        meet = (a == '0) | (b == '0) | (a[KW-1] != b[KW-1]);
    endfunction

    always_comb begin
        ca[OC_LEFT]  = i_start_x < i_box_min_x;
        ca[OC_RIGHT] = i_start_x > i_box_max_x;
        ca[OC_BELOW] = i_start_y < i_box_min_y;
        ca[OC_ABOVE] = i_start_y > i_box_max_y;
        cb[OC_LEFT]  = i_end_x < i_box_min_x;
        cb[OC_RIGHT] = i_end_x > i_box_max_x;
        cb[OC_BELOW] = i_end_y < i_box_min_y;
        cb[OC_ABOVE] = i_end_y > i_box_max_y;
        cor          = ca | cb;

        n_fix     = 1'b1;
        n_fix_hit = 1'b1;
        if ((ca & cb) != 4'd0) begin
            n_fix_hit = 1'b0;
        end else if (ca == 4'd0 || cb == 4'd0) begin
            n_fix_hit = 1'b1;
        end else if (cor == OC_STRADDLE_X || cor == OC_STRADDLE_Y) begin
            n_fix_hit = 1'b1;
        end else begin
            n_fix = 1'b0;
        end

        // endpoints on opposite sides (or on) each edge's supporting line
        n_edge_ok[0] = (i_box_max_y == i_box_min_y) |
                       straddle(i_start_x < i_box_min_x, i_start_x == i_box_min_x,
                                i_end_x < i_box_min_x, i_end_x == i_box_min_x);
        n_edge_ok[1] = (i_box_max_y == i_box_min_y) |
                       straddle(i_start_x < i_box_max_x, i_start_x == i_box_max_x,
                                i_end_x < i_box_max_x, i_end_x == i_box_max_x);
        n_edge_ok[2] = (i_box_max_x == i_box_min_x) |
                       straddle(i_start_y < i_box_min_y, i_start_y == i_box_min_y,
                                i_end_y < i_box_min_y, i_end_y == i_box_min_y);
        n_edge_ok[3] = (i_box_max_x == i_box_min_x) |
                       straddle(i_start_y < i_box_max_y, i_start_y == i_box_max_y,
                                i_end_y < i_box_max_y, i_end_y == i_box_max_y);

        n_dx = DW'(i_end_x)     - DW'(i_start_x);
        n_dy = DW'(i_end_y)     - DW'(i_start_y);
        n_ll = DW'(i_box_min_x) - DW'(i_start_x);
        n_rr = DW'(i_box_max_x) - DW'(i_start_x);
        n_tt = DW'(i_box_min_y) - DW'(i_start_y);
        n_bb = DW'(i_box_max_y) - DW'(i_start_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_dx      <= n_dx;
            r1_dy      <= n_dy;
            r1_ll      <= n_ll;
            r1_rr      <= n_rr;
            r1_tt      <= n_tt;
            r1_bb      <= n_bb;
            r1_edge_ok <= n_edge_ok;
            r1_fix     <= n_fix;
            r1_fix_hit <= n_fix_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_dxt     <= PW'(r1_dx) * PW'(r1_tt);
            r2_dxb     <= PW'(r1_dx) * PW'(r1_bb);
            r2_dyl     <= PW'(r1_dy) * PW'(r1_ll);
            r2_dyr     <= PW'(r1_dy) * PW'(r1_rr);
            r2_edge_ok <= r1_edge_ok;
            r2_fix     <= r1_fix;
            r2_fix_hit <= r1_fix_hit;
        end
    end

    // side of each box corner relative to the segment line
    always_comb begin
        k_lt  = KW'(r2_dxt) - KW'(r2_dyl);
        k_lb  = KW'(r2_dxb) - KW'(r2_dyl);
        k_rt  = KW'(r2_dxt) - KW'(r2_dyr);
        k_rb  = KW'(r2_dxb) - KW'(r2_dyr);
        n_hit = (r2_edge_ok[0] & meet(k_lt, k_lb)) |
                (r2_edge_ok[1] & meet(k_rt, k_rb)) |
                (r2_edge_ok[2] & meet(k_lt, k_rt)) |
                (r2_edge_ok[3] & meet(k_lb, k_rb));
        if (r2_fix) begin
            n_hit = r2_fix_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_hit <= n_hit;
        end
    end

    assign o_hit = r3_hit;

endmodule

[sv/sbi_checker.sv]
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks for the segment / box test, bound to the top level.
// ----------------------------------------------------------------------------
module sbi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_hit
);
    // request backpressure only when the result side is stalled
    a_ready_low_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> (i_rsp_valid && !i_rsp_ready))
        else $error("request ready low without result stall");

    // empty pipeline never blocks a request
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request blocked with no pending result");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_hit)))
        else $error("stalled result dropped or changed");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind segment_box_intersect_test sbi_checker u_sbi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_hit   (o_rsp.hit)
);

[tb/sv/segment_hit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_hit_checker
// Watches the request and result channels of the segment / box hit test.
// Predicts each hit flag from the accepted request and checks the results in
// order, counting mismatches and reporting the number of results still owed.
// ----------------------------------------------------------------------------
module segment_hit_checker #(
    parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbi_req_if   i_req,
    sbi_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import sbi_pkg::*;

    typedef struct {
        bit          hit;
        int unsigned seq_no;
    } t_hit_entry;

    t_hit_entry  expected_hits[$];
    int unsigned req_seq;

    function automatic logic [3:0] region_code(longint x, longint y, longint lx, longint ly,
                                               longint hx, longint hy);
        logic [3:0] code;
        code = '0;
        code[OC_LEFT]  = (x < lx);
        code[OC_RIGHT] = (x > hx);
        code[OC_BELOW] = (y < ly);
        code[OC_ABOVE] = (y > hy);
        return code;
    endfunction

    // sign of the turn p -> q -> r; 17-bit deltas keep the products exact in 64 bits
    function automatic int turn_sign(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
        longint area;
        area = (qx - px) * (ry - py) - (qy - py) * (rx - px);
        return (area > 0) ? 1 : ((area < 0) ? -1 : 0);
    endfunction

    function automatic bit segments_touch(longint ax, longint ay, longint bx, longint by,
                                          longint cx, longint cy, longint dx, longint dy);
        return (turn_sign(ax, ay, bx, by, cx, cy) * turn_sign(ax, ay, bx, by, dx, dy) <= 0) &&
               (turn_sign(cx, cy, dx, dy, ax, ay) * turn_sign(cx, cy, dx, dy, bx, by) <= 0);
    endfunction

    function automatic bit predict_hit(
        logic signed [COORD_WIDTH-1:0] box_min_x, logic signed [COORD_WIDTH-1:0] box_min_y,
        logic signed [COORD_WIDTH-1:0] box_max_x, logic signed [COORD_WIDTH-1:0] box_max_y,
        logic signed [COORD_WIDTH-1:0] start_x,   logic signed [COORD_WIDTH-1:0] start_y,
        logic signed [COORD_WIDTH-1:0] end_x,     logic signed [COORD_WIDTH-1:0] end_y
    );
        longint     lx, ly, hx, hy, x1, y1, x2, y2;
        logic [3:0] code_a, code_b, code_or;
        lx = box_min_x;
        ly = box_min_y;
        hx = box_max_x;
        hy = box_max_y;
        x1 = start_x;
        y1 = start_y;
        x2 = end_x;
        y2 = end_y;
        code_a  = region_code(x1, y1, lx, ly, hx, hy);
        code_b  = region_code(x2, y2, lx, ly, hx, hy);
        code_or = code_a | code_b;
        if ((code_a & code_b) != '0)
            return 1'b0;
        if (code_a == '0 || code_b == '0)
            return 1'b1;
        if (code_or == OC_STRADDLE_X || code_or == OC_STRADDLE_Y)
            return 1'b1;
        return segments_touch(lx, ly, lx, hy, x1, y1, x2, y2) ||
               segments_touch(hx, ly, hx, hy, x1, y1, x2, y2) ||
               segments_touch(lx, ly, hx, ly, x1, y1, x2, y2) ||
               segments_touch(lx, hy, hx, hy, x1, y1, x2, y2);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        req_seq      = 0;
    end

    always @(posedge i_clk) begin
        t_hit_entry want;
        if (!i_rst_n) begin
            expected_hits.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                want.hit    = predict_hit(i_req.box_min_x, i_req.box_min_y,
                                          i_req.box_max_x, i_req.box_max_y,
                                          i_req.start_x, i_req.start_y,
                                          i_req.end_x, i_req.end_y);
                want.seq_no = req_seq;
                req_seq++;
                expected_hits.push_back(want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, hit=%b", i_rsp.hit));
                end else begin
                    want = expected_hits.pop_front();
                    if (i_rsp.hit !== want.hit)
                        report_mismatch($sformatf("request %0d: hit=%b, predicted %b",
                                                  want.seq_no, i_rsp.hit, want.hit));
                end
            end
        end
        o_pending = expected_hits.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the segment / box hit test.
// A directed set covers extreme coordinates, every outcode path, corner
// touches, degenerate and inverted boxes; then random requests built mostly
// around a box at several scales. Both channels idle at random, and the
// result side holds off once for a long stretch so the pipeline backs up.
// ----------------------------------------------------------------------------
module testbench;
    import sbi_pkg::*;

    localparam int  COORD_W      = COORD_WIDTH_DEF;
    localparam time CLK_PERIOD   = 20ns;
    localparam int  RANDOM_ITEMS = 1250;
    localparam int  LONG_HOLD    = 300;
    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   hold_now;

    sbi_req_if #(.COORD_WIDTH(COORD_W)) req_ch ();
    sbi_rsp_if                          rsp_ch ();

    segment_box_intersect_test #(.COORD_WIDTH(COORD_W)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    segment_hit_checker #(.COORD_WIDTH(COORD_W)) CHK (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int near_coord(int c, int span);
        return clamp_coord(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            6: return 32767;
            default: return any_coord();
        endcase
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // entered and left at a falling edge
    task automatic send_request(input int lx, input int ly, input int hx, input int hy,
                                input int x1, input int y1, input int x2, input int y2,
                                input int gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.box_min_x <= COORD_W'(lx);
        req_ch.box_min_y <= COORD_W'(ly);
        req_ch.box_max_x <= COORD_W'(hx);
        req_ch.box_max_y <= COORD_W'(hy);
        req_ch.start_x   <= COORD_W'(x1);
        req_ch.start_y   <= COORD_W'(y1);
        req_ch.end_x     <= COORD_W'(x2);
        req_ch.end_y     <= COORD_W'(y2);
        req_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_request(input int gap);
        int cx, cy, hw, hh, span, lx, ly, hx, hy, swap_tmp;
        int x1, y1, x2, y2;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_request(any_coord(), any_coord(), any_coord(), any_coord(),
                         any_coord(), any_coord(), any_coord(), any_coord(), gap);
        end else if (kind < 20) begin
            send_request(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                         extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                         gap);
        end else begin
            case ($urandom_range(0, 3))
                0: begin hw = $urandom_range(0, 4);     hh = $urandom_range(0, 4);     end
                1: begin hw = $urandom_range(0, 64);    hh = $urandom_range(0, 64);    end
                2: begin hw = $urandom_range(0, 2048);  hh = $urandom_range(0, 2048);  end
                default: begin hw = $urandom_range(0, 20000); hh = $urandom_range(0, 20000); end
            endcase
            cx   = any_coord();
            cy   = any_coord();
            lx   = clamp_coord(cx - hw);
            hx   = clamp_coord(cx + hw);
            ly   = clamp_coord(cy - hh);
            hy   = clamp_coord(cy + hh);
            span = 2 * ((hw > hh) ? hw : hh) + 3;
            x1   = near_coord(cx, span);
            y1   = near_coord(cy, span);
            x2   = near_coord(cx, span);
            y2   = near_coord(cy, span);
            if ($urandom_range(0, 19) == 0) begin
                swap_tmp = lx;
                lx       = hx;
                hx       = swap_tmp;
            end
            if ($urandom_range(0, 19) == 0) begin
                swap_tmp = ly;
                ly       = hy;
                hy       = swap_tmp;
            end
            send_request(lx, ly, hx, hy, x1, y1, x2, y2, gap);
        end
    endtask

    // result side: random ready runs, one long hold-off on request
    initial begin
        bit run_ready;
        int run_len;
        bit hold_done;
        int r;
        rsp_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (hold_now && !hold_done) begin
                hold_done = 1'b1;
                run_ready = 1'b0;
                run_len   = LONG_HOLD;
            end else if (r < 10) begin
                run_ready = 1'b1;
                run_len   = $urandom_range(60, 150);
            end else if (r < 60) begin
                run_ready = 1'b1;
                run_len   = $urandom_range(1, 8);
            end else if (r < 92) begin
                run_ready = 1'b0;
                run_len   = $urandom_range(1, 3);
            end else begin
                run_ready = 1'b0;
                run_len   = $urandom_range(10, 40);
            end
            @(negedge clk);
            rsp_ch.ready <= run_ready;
            repeat (run_len - 1) @(negedge clk);
        end
    end

    initial begin
        hold_now         = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.box_min_x = '0;
        req_ch.box_min_y = '0;
        req_ch.box_max_x = '0;
        req_ch.box_max_y = '0;
        req_ch.start_x   = '0;
        req_ch.start_y   = '0;
        req_ch.end_x     = '0;
        req_ch.end_y     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
        send_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        send_request(-100, -100, 100, 100, -10, -10, 10, 10, 0);      // both inside
        send_request(-100, -100, 100, 100, 0, 0, 500, 20, 1);         // one inside
        send_request(0, 0, 10, 10, -20, 3, -1, 7, 0);                 // both left
        send_request(0, 0, 10, 10, 11, -5, 40, -9, 0);                // both right/below
        send_request(0, 0, 10, 10, -5, 5, 15, 5, 2);                  // left/right straddle
        send_request(0, 0, 10, 10, 5, -5, 5, 15, 0);                  // below/above straddle
        send_request(0, 0, 10, 10, -5, -5, 15, 15, 0);                // diagonal through
        send_request(0, 0, 10, 10, -5, 5, 5, 15, 0);                  // corner touch
        send_request(0, 0, 10, 10, -6, 5, 5, 16, 3);                  // corner near miss
        send_request(0, 0, 10, 10, -5, 12, 12, -5, 0);                // anti-diagonal through
        send_request(10, 10, 0, 0, 5, 5, 6, 6, 0);                    // inverted box
        send_request(10, 0, 0, 10, 5, 5, 6, 6, 0);                    // inverted in x
        send_request(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 0);
        send_request(-1, -1, 1, 1, -32768, 32767, 32767, -32768, 0);  // wide edge test
        send_request(0, 0, 10, 10, -32768, 5, 5, 32767, 1);           // wide miss
        send_request(0, 0, 10, 10, 20, 20, 20, 20, 0);                // point outside
        send_request(0, 0, 10, 10, 10, 10, 10, 10, 0);                // point on corner
        send_request(0, 0, 0, 0, -3, 3, 3, -3, 0);                    // zero-size box
        send_request(0, 0, 10, 10, 10, 15, 15, 10, 0);                // passes the corner
        send_request(0, 0, 10, 10, 5, 15, 15, 5, 0);                  // grazes the corner

        // random
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200)
                hold_now = 1'b1;
            send_random_request(pick_gap(((n / 100) % 4) == 1 || (n >= 200 && n < 260)));
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
